@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/aslp_pkg.sv @@
package aslp_pkg;

    localparam int NUM_FIELDS  = 9;
    localparam int OUT_BITS    = 32;
    localparam int FIELD_IDX_W = 4;

    typedef logic [FIELD_IDX_W-1:0] field_idx_t;
    typedef logic [7:0]             char_t;

    // Field slots
    localparam field_idx_t FIELD_SEQ   = 4'd0;
    localparam field_idx_t FIELD_CHAN0 = 4'd1;
    localparam field_idx_t FIELD_STAMP = 4'd7;
    localparam field_idx_t FIELD_DELTA = 4'd8;

    // Characters of the line format
    localparam char_t CHAR_EQ    = 8'h3D;  // '='
    localparam char_t CHAR_H     = 8'h68;  // 'h'
    localparam char_t CHAR_NL    = 8'h0A;  // newline
    localparam char_t CHAR_ZERO  = 8'h30;  // '0'
    localparam char_t CHAR_FIVE  = 8'h35;  // '5'
    localparam char_t CHAR_NINE  = 8'h39;  // '9'
    localparam char_t CHAR_O     = 8'h6F;  // 'o'
    localparam char_t CHAR_M     = 8'h6D;  // 'm'
    localparam char_t CHAR_X     = 8'h78;  // 'x'
    localparam char_t CHAR_S     = 8'h73;  // 's'
    localparam char_t CHAR_A     = 8'h61;  // 'a'

    // Map the key byte in front of '=' onto a field; unknown keys keep the current one.
    function automatic field_idx_t pick_field(input char_t sel, input field_idx_t keep);
        field_idx_t res;
        res = keep;
        if (sel == CHAR_O || sel == CHAR_M || sel == CHAR_X)
        begin
            res = FIELD_SEQ;
        end
        else if (sel >= CHAR_ZERO && sel <= CHAR_FIVE)
        begin
            res = FIELD_CHAN0 + field_idx_t'(sel[2:0]);
        end
        else if (sel == CHAR_S)
        begin
            res = FIELD_STAMP;
        end
        else if (sel == CHAR_A)
        begin
            res = FIELD_DELTA;
        end
        return res;
    endfunction

endpackage

@@ rtl/ascii_sample_line_parser_core.sv @@
// ASCII sample line parser. Takes one text byte per request from a stream of
// key=value lines and keeps nine numeric fields: sequence number, six channel
// values, timestamp and delta. On '=' the byte before it selects the field,
// which is cleared; decimal digits are folded in as value*10+digit (a digit
// right after 'h' is skipped); values wrap modulo 2^VALUE_BITS. Each newline
// delivers one result request carrying the low 32 bits of all nine fields;
// the fields keep their values. Throughput is one byte per clock, sustained,
// as long as results are taken; a newline meeting a stalled result holds the
// input side until the result leaves. A byte is registered on acceptance and
// processed from that register; a newline there sets the registered out_valid
// and snapshots the fields, waiting while a stalled result is still held.
// The per-byte limit is the read-modify-write of the active field (select,
// shift-add by ten, write back).
module ascii_sample_line_parser_core
    import aslp_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_BITS-1:0] seq_number,
    output logic [OUT_BITS-1:0] chan_a,
    output logic [OUT_BITS-1:0] chan_b,
    output logic [OUT_BITS-1:0] chan_c,
    output logic [OUT_BITS-1:0] chan_d,
    output logic [OUT_BITS-1:0] chan_e,
    output logic [OUT_BITS-1:0] chan_f,
    output logic [OUT_BITS-1:0] time_stamp,
    output logic [OUT_BITS-1:0] time_delta
);

    typedef logic [VALUE_BITS-1:0] value_t;

    // Input register
    logic       in_valid_reg;
    char_t      in_byte_reg;

    // Parser state
    char_t      last_byte_reg, last_byte_next;
    field_idx_t active_reg, active_next;
    value_t     field_reg  [NUM_FIELDS];
    value_t     field_next [NUM_FIELDS];

    // Result register
    logic          out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0] out_data_reg [NUM_FIELDS];

    // Decode of the byte under work
    logic       is_eq, is_digit, is_nl;
    logic       proc_ok, proc;
    field_idx_t cur_f, sel_f;
    value_t     cur_val, acc_val;

    assign is_eq    = (in_byte_reg == CHAR_EQ);
    assign is_digit = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    assign is_nl    = (in_byte_reg == CHAR_NL);

    // Only a newline needs the result register; everything else goes straight through.
    assign proc_ok  = !is_nl || !out_valid_reg || out_ready;
    assign proc     = in_valid_reg && proc_ok;
    assign in_ready = !in_valid_reg || proc_ok;

    // Guard against an out-of-range field index
    assign cur_f   = (active_reg < field_idx_t'(NUM_FIELDS)) ? active_reg : FIELD_SEQ;
    assign sel_f   = is_eq ? pick_field(last_byte_reg, cur_f) : cur_f;
    assign cur_val = field_reg[cur_f];
    // value*10 + digit as two shifted adds; wraps at VALUE_BITS
    assign acc_val = (cur_val << 3) + (cur_val << 1) + value_t'(in_byte_reg[3:0]);

    always_comb
    begin
        last_byte_next = last_byte_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !out_ready;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            field_next[i] = field_reg[i];
        end

        if (proc)
        begin
            last_byte_next = in_byte_reg;
            active_next    = sel_f;
            if (is_eq)
            begin
                field_next[sel_f] = '0;
            end
            else if (is_digit && last_byte_reg != CHAR_H)
            begin
                field_next[cur_f] = acc_val;
            end
            else if (is_nl)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            last_byte_reg <= '0;
            active_reg    <= FIELD_SEQ;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                field_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            last_byte_reg <= last_byte_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                field_reg[i] <= field_next[i];
            end
        end
    end

    // Payload registers: capture the byte on accept, snapshot fields on newline.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
        if (proc && is_nl)
        begin
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                out_data_reg[i] <= OUT_BITS'(field_reg[i]);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign seq_number = out_data_reg[0];
    assign chan_a     = out_data_reg[1];
    assign chan_b     = out_data_reg[2];
    assign chan_c     = out_data_reg[3];
    assign chan_d     = out_data_reg[4];
    assign chan_e     = out_data_reg[5];
    assign chan_f     = out_data_reg[6];
    assign time_stamp = out_data_reg[7];
    assign time_delta = out_data_reg[8];

endmodule

@@ rtl/aslp_checker.sv @@
`include "assert_macros.svh"

module aslp_checker
    import aslp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [7:0]          in_byte,
    input logic                out_valid,
    input logic                out_ready,
    input logic [OUT_BITS-1:0] seq_number,
    input logic [OUT_BITS-1:0] chan_a,
    input logic [OUT_BITS-1:0] chan_b,
    input logic [OUT_BITS-1:0] chan_c,
    input logic [OUT_BITS-1:0] chan_d,
    input logic [OUT_BITS-1:0] chan_e,
    input logic [OUT_BITS-1:0] chan_f,
    input logic [OUT_BITS-1:0] time_stamp,
    input logic [OUT_BITS-1:0] time_delta
);

    // A fresh result must trace back to an accepted newline.
    `ASSERT_CLK(a_result_from_newline, clk, rst_n,
        $rose(out_valid) |-> $past(in_valid && in_ready && in_byte == CHAR_NL, 2),
        "result without a newline")

    // Input back-pressure only comes from a stalled result.
    `ASSERT_CLK(a_ready_only_on_stall, clk, rst_n,
        !in_ready |-> (out_valid && !out_ready),
        "input stalled without output stall")

    // Hold a stalled result.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
        "result dropped while stalled")

    // Hold the stalled result payload.
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
        $stable(seq_number) && $stable(chan_a) && $stable(chan_b) && $stable(chan_c)
        && $stable(chan_d) && $stable(chan_e) && $stable(chan_f)
        && $stable(time_stamp) && $stable(time_delta),
        "result changed while stalled")

endmodule

bind ascii_sample_line_parser_core aslp_checker u_aslp_checker (.*);
